### design/optimal_page_replacement_top_macros.svh
// assertion macros shared by the design files
// no dependencies; the assertions use clk_i and rst_ni of the including module
`ifndef OPTIMAL_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define OPTIMAL_PAGE_REPLACEMENT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define OPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OPR_ASSERT_NEVER(lbl, cond, msg) `OPR_ASSERT(lbl, !(cond), msg)
`else
`define OPR_ASSERT(lbl, prop, msg)
`define OPR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### design/opr_pkg.sv
// constants and defaults for the optimal page replacement block
// no dependencies
package opr_pkg;

  localparam int MaxRefsDef   = 32;
  localparam int MaxFramesDef = 8;
  localparam int PageBitsDef  = 16;

  localparam int PageW  = 16;
  localparam int CntW   = 6;
  localparam int FcW    = 4;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [FcW-1:0] FrameCountReset = 4'd4;
  localparam logic [0:0]     RegFrameCount   = 1'b0;

endpackage

### design/opr_if.sv
// stream interfaces for the reference and result channels
// depends on opr_pkg
interface opr_ref_if;
  logic                       valid;
  logic                       ready;
  logic [opr_pkg::PageW-1:0]  page_number;
  logic                       last_ref;

  modport source (output valid, output page_number, output last_ref, input ready);
  modport sink   (input valid, input page_number, input last_ref, output ready);
endinterface

interface opr_res_if;
  logic                       valid;
  logic                       ready;
  logic [opr_pkg::PageW-1:0]  slot_page;
  logic                       slot_valid;
  logic [opr_pkg::CntW-1:0]   hit_count;
  logic [opr_pkg::CntW-1:0]   miss_count;
  logic                       overflow;
  logic                       last_slot;

  modport source (output valid, output slot_page, output slot_valid, output hit_count,
                  output miss_count, output overflow, output last_slot, input ready);
  modport sink   (input valid, input slot_page, input slot_valid, input hit_count,
                  input miss_count, input overflow, input last_slot, output ready);
endinterface

### design/optimal_page_replacement_top.sv
// optimal (belady) page replacement over a stored reference string
// depends on opr_pkg, opr_if, opr_ram and optimal_page_replacement_top_macros.svh
//
// usage:
//   in_i carries one page reference per transaction; references are stored in a
//   ram of MAX_REFS entries at one per cycle. references past capacity are dropped
//   and set the overflow flag. the transaction with last_ref set starts the run.
//   the run uses frame_count frames (apb register at byte 0, reset 4, clamped to
//   1..MAX_FRAMES, sampled with the last reference).
//   out_o then delivers one transaction per frame, frame 0 first, last_slot on the
//   final one. in_i is not ready while a run is in progress.
//   after the last reference, each stored reference is fetched from the ram and
//   compared against all frames in parallel; each eviction then scans every later
//   reference with one ram read each, and the results for each frame follow;
//   the scan is serial, set by the single read port of the reference ram.
//   a stalled receiver holds the output register; results advance one per cycle
//   while out_o.ready is high. after the final result the next string is taken
//   while that result still waits.
//   reset clears the reference count and flags and sets the frame count register
//   to 4; no clearing pass runs.
`include "optimal_page_replacement_top_macros.svh"
module optimal_page_replacement_top #(
  parameter int MAX_REFS   = opr_pkg::MaxRefsDef,
  parameter int MAX_FRAMES = opr_pkg::MaxFramesDef,
  parameter int PAGE_BITS  = opr_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  opr_ref_if.sink                       in_i,
  opr_res_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [opr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [opr_pkg::CfgDataW-1:0]  pwdata,
  output logic [opr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int RefIdxW  = $clog2(MAX_REFS);
  localparam int RefCntW  = $clog2(MAX_REFS + 1);
  localparam int FrIdxW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NfW      = $clog2(MAX_FRAMES + 1);
  localparam int WideBits = (PAGE_BITS > opr_pkg::PageW) ? PAGE_BITS : opr_pkg::PageW;

  typedef enum logic [2:0] {
    S_LOAD, S_FETCH, S_CMP, S_SREQ, S_SCHK, S_OUT
  } state_e;

  typedef logic [PAGE_BITS-1:0] page_t;

  state_e                   state_q;
  logic [RefCntW-1:0]       total_q, i_q, k_q;
  logic [NfW-1:0]           nf_q, j_q;
  logic [MAX_FRAMES-1:0]    vld_q, found_q;
  logic [FrIdxW-1:0]        last_q;
  logic [opr_pkg::CntW-1:0] hits_q, misses_q;
  logic                     ovf_q;
  logic [opr_pkg::FcW-1:0]  fc_q;
  logic                     out_vld_q;
  page_t                    cur_pg_q;
  page_t                    frames_q [MAX_FRAMES];

  logic [opr_pkg::PageW-1:0] slot_page_q;
  logic                      slot_valid_q, last_slot_q, ovf_out_q;
  logic [opr_pkg::CntW-1:0]  hit_out_q, miss_out_q;

  // configuration port
  logic cfg_wr, cfg_hit;
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == opr_pkg::RegFrameCount);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? opr_pkg::CfgDataW'(fc_q) : '0;

  // input page masked to the page width
  logic [WideBits-1:0] pg_wide;
  page_t               pg_in;
  assign pg_wide = WideBits'(in_i.page_number);
  assign pg_in   = pg_wide[PAGE_BITS-1:0];

  logic in_acc, out_acc, store_wr, load_adv;
  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign store_wr   = in_acc && (total_q < RefCntW'(MAX_REFS));
  assign load_adv   = !out_vld_q || out_o.ready;

  // reference store
  logic [RefIdxW-1:0] raddr;
  page_t              rdata;
  always_comb begin
    raddr = i_q[RefIdxW-1:0];
    if (state_q == S_SREQ) begin
      raddr = k_q[RefIdxW-1:0];
    end
  end

  opr_ram #(.Width(PAGE_BITS), .Depth(MAX_REFS)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (store_wr),
    .waddr_i (total_q[RefIdxW-1:0]),
    .wdata_i (pg_in),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // clamped frame count
  logic [7:0]     fc_w;
  logic [NfW-1:0] nf_new;
  always_comb begin
    fc_w = 8'(fc_q);
    if (fc_w == 8'd0) begin
      nf_new = NfW'(1);
    end else if (fc_w > 8'(MAX_FRAMES)) begin
      nf_new = NfW'(MAX_FRAMES);
    end else begin
      nf_new = NfW'(fc_w);
    end
  end

  function automatic logic [FrIdxW-1:0] lowest(input logic [MAX_FRAMES-1:0] v);
    logic [FrIdxW-1:0] r;
    r = '0;
    for (int n = MAX_FRAMES - 1; n >= 0; n--) begin
      if (v[n]) begin
        r = FrIdxW'(n);
      end
    end
    return r;
  endfunction

  function automatic logic [FrIdxW-1:0] encode(input logic [MAX_FRAMES-1:0] v);
    logic [FrIdxW-1:0] r;
    r = '0;
    for (int n = 0; n < MAX_FRAMES; n++) begin
      if (v[n]) begin
        r = r | FrIdxW'(n);
      end
    end
    return r;
  endfunction

  // frame lanes compared in parallel against the word read from the store
  logic [MAX_FRAMES-1:0] lane_use, match, empty, fresh, found_nx, unfound;
  logic                  hit, has_empty;
  logic [FrIdxW-1:0]     empty_idx, victim;
  always_comb begin
    for (int n = 0; n < MAX_FRAMES; n++) begin
      lane_use[n] = (NfW'(n) < nf_q);
      match[n]    = vld_q[n] && lane_use[n] && (frames_q[n] == rdata);
    end
    hit       = |match;
    empty     = lane_use & ~vld_q;
    has_empty = |empty;
    empty_idx = lowest(empty);
    fresh     = match & ~found_q;
    found_nx  = found_q | match;
    unfound   = lane_use & ~found_nx;
    if (|unfound) begin
      victim = lowest(unfound);
    end else if (|fresh) begin
      victim = encode(fresh);
    end else begin
      victim = last_q;
    end
  end

  logic [RefCntW-1:0] i_nx, k_nx;
  assign i_nx = i_q + RefCntW'(1);
  assign k_nx = k_q + RefCntW'(1);

  // frame replacement
  logic              fr_we;
  logic [FrIdxW-1:0] fr_idx;
  always_comb begin
    fr_we  = 1'b0;
    fr_idx = '0;
    case (state_q)
      S_CMP: begin
        if (!hit && (has_empty || i_nx == total_q)) begin
          fr_we  = 1'b1;
          fr_idx = has_empty ? empty_idx : '0;
        end
      end
      S_SCHK: begin
        if (k_nx == total_q) begin
          fr_we  = 1'b1;
          fr_idx = victim;
        end
      end
      default: ;
    endcase
  end

  logic done_ref;
  assign done_ref = fr_we || ((state_q == S_CMP) && hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      total_q   <= '0;
      i_q       <= '0;
      k_q       <= '0;
      nf_q      <= NfW'(1);
      j_q       <= '0;
      vld_q     <= '0;
      found_q   <= '0;
      last_q    <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      ovf_q     <= 1'b0;
      fc_q      <= opr_pkg::FrameCountReset;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fc_q <= pwdata[opr_pkg::FcW-1:0];
      end
      if (out_acc && !((state_q == S_OUT) && load_adv)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (store_wr) begin
              total_q <= total_q + RefCntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.last_ref) begin
              nf_q     <= nf_new;
              vld_q    <= '0;
              hits_q   <= '0;
              misses_q <= '0;
              i_q      <= '0;
              state_q  <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            hits_q <= hits_q + opr_pkg::CntW'(1);
          end else begin
            misses_q <= misses_q + opr_pkg::CntW'(1);
            if (!has_empty && i_nx != total_q) begin
              found_q <= '0;
              k_q     <= i_nx;
              state_q <= S_SREQ;
            end
          end
        end
        S_SREQ: begin
          state_q <= S_SCHK;
        end
        S_SCHK: begin
          found_q <= found_nx;
          if (|fresh) begin
            last_q <= encode(fresh);
          end
          if (k_nx != total_q) begin
            k_q     <= k_nx;
            state_q <= S_SREQ;
          end
        end
        S_OUT: begin
          if (load_adv) begin
            out_vld_q <= 1'b1;
            if (j_q + NfW'(1) == nf_q) begin
              total_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              j_q <= j_q + NfW'(1);
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
      if (fr_we) begin
        vld_q[fr_idx] <= 1'b1;
      end
      if (done_ref) begin
        i_q <= i_nx;
        if (i_nx == total_q) begin
          j_q     <= '0;
          state_q <= S_OUT;
        end else begin
          state_q <= S_FETCH;
        end
      end
    end
  end

  // datapath registers
  logic [WideBits-1:0] out_wide;
  assign out_wide = WideBits'(frames_q[j_q[FrIdxW-1:0]]);

  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP) begin
      cur_pg_q <= rdata;
    end
    if (fr_we) begin
      frames_q[fr_idx] <= (state_q == S_CMP) ? rdata : cur_pg_q;
    end
    if ((state_q == S_OUT) && load_adv) begin
      slot_valid_q <= vld_q[j_q[FrIdxW-1:0]];
      slot_page_q  <= vld_q[j_q[FrIdxW-1:0]] ? out_wide[opr_pkg::PageW-1:0] : '0;
      hit_out_q    <= hits_q;
      miss_out_q   <= misses_q;
      ovf_out_q    <= ovf_q;
      last_slot_q  <= (j_q + NfW'(1) == nf_q);
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.slot_page  = slot_page_q;
  assign out_o.slot_valid = slot_valid_q;
  assign out_o.hit_count  = hit_out_q;
  assign out_o.miss_count = miss_out_q;
  assign out_o.overflow   = ovf_out_q;
  assign out_o.last_slot  = last_slot_q;

  `OPR_ASSERT_NEVER(a_vld_in_use, (state_q != S_LOAD) && ((vld_q & ~lane_use) != '0), "frame valid outside frame count")
  `OPR_ASSERT(a_count_sum, (state_q == S_FETCH) |-> (opr_pkg::CntW'(hits_q + misses_q) == opr_pkg::CntW'(i_q)), "hit and miss totals disagree with position")
  `OPR_ASSERT(a_scan_full, (state_q == S_SREQ) |-> ((vld_q & lane_use) == lane_use), "victim scan with an empty frame")
  `OPR_ASSERT(a_overflow, (in_acc && (total_q == RefCntW'(MAX_REFS))) |=> ovf_q || (state_q == S_FETCH), "dropped reference did not set overflow")

endmodule

### design/opr_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module opr_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### dv/tb.sv
// testbench for optimal_page_replacement_top: reference strings in, one report per frame out
// depends on opr_pkg, opr_if and the design; predicts every frame report with its own
// belady replay and checks each result transaction in order
`timescale 1ns / 1ps

module tb;
  import opr_pkg::*;

  localparam logic [CfgAddrW-1:0] FrameCountAddr = CfgAddrW'(RegFrameCount) << 2;
  localparam logic [CfgAddrW-1:0] UnmappedAddr   = CfgAddrW'(4);
  localparam int SettleCycles   = 16;
  localparam int WatchdogLimit  = 20000;
  localparam int IdlePercent    = 26;
  localparam int RandomRefs     = 165;
  localparam int ReportLimit    = 10;

  typedef struct packed {
    logic [PageW-1:0] slot_page;
    logic             slot_valid;
    logic [CntW-1:0]  hit_count;
    logic [CntW-1:0]  miss_count;
    logic             overflow;
    logic             last_slot;
  } frame_report_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  opr_ref_if ref_bus ();
  opr_res_if res_bus ();

  optimal_page_replacement_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ref_bus),
    .out_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_report_t    frame_reports_q[$];
  logic [PageW-1:0] stored_pages[$];
  bit               store_overflow;
  logic [FcW-1:0]   frame_count_model = FrameCountReset;

  int  failures;
  int  stall_cycles;
  int  strings_sent;
  int  refs_sent;
  int  reports_seen;
  int  config_writes;
  bit  steady_flow;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= ReportLimit) $display("%s", msg);
  endtask

  // belady replay of the stored string, queues one report per frame in use
  function automatic void replay_belady();
    logic [PageW-1:0] frame_pg[MaxFramesDef];
    bit               frame_vld[MaxFramesDef];
    frame_report_t    rpt;
    int               nf, n, victim, far, nxt, hit_total, miss_total;
    bit               hit, placed;
    nf = int'(frame_count_model);
    if (nf < 1) nf = 1;
    if (nf > MaxFramesDef) nf = MaxFramesDef;
    n = stored_pages.size();
    foreach (frame_vld[j]) begin
      frame_vld[j] = 1'b0;
      frame_pg[j]  = '0;
    end
    hit_total  = 0;
    miss_total = 0;
    for (int i = 0; i < n; i++) begin
      hit = 1'b0;
      for (int j = 0; j < nf; j++) begin
        if (frame_vld[j] && frame_pg[j] == stored_pages[i]) hit = 1'b1;
      end
      if (hit) begin
        hit_total++;
        continue;
      end
      miss_total++;
      placed = 1'b0;
      for (int j = 0; j < nf && !placed; j++) begin
        if (!frame_vld[j]) begin
          frame_vld[j] = 1'b1;
          frame_pg[j]  = stored_pages[i];
          placed       = 1'b1;
        end
      end
      if (!placed) begin
        victim = 0;
        far    = 0;
        for (int j = 0; j < nf; j++) begin
          nxt = n;
          for (int k = n - 1; k > i; k--) begin
            if (stored_pages[k] == frame_pg[j]) nxt = k;
          end
          if (nxt >= n) begin
            victim = j;
            break;
          end
          if (j == 0 || nxt > far) begin
            far    = nxt;
            victim = j;
          end
        end
        frame_pg[victim] = stored_pages[i];
      end
    end
    for (int j = 0; j < nf; j++) begin
      rpt.slot_page  = frame_vld[j] ? frame_pg[j] : '0;
      rpt.slot_valid = frame_vld[j];
      rpt.hit_count  = CntW'(hit_total);
      rpt.miss_count = CntW'(miss_total);
      rpt.overflow   = store_overflow;
      rpt.last_slot  = (j == nf - 1);
      frame_reports_q.push_back(rpt);
    end
    stored_pages.delete();
    store_overflow = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && ref_bus.valid && ref_bus.ready) begin
      if (stored_pages.size() < MaxRefsDef) stored_pages.push_back(ref_bus.page_number);
      else store_overflow = 1'b1;
      if (ref_bus.last_ref) replay_belady();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready && paddr == FrameCountAddr) begin
      frame_count_model = pwdata[FcW-1:0];
    end
  end

  always @(posedge clk_i) begin
    frame_report_t got, want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.slot_page, res_bus.slot_valid, res_bus.hit_count, res_bus.miss_count,
              res_bus.overflow, res_bus.last_slot};
      reports_seen++;
      if (frame_reports_q.size() == 0) begin
        note_failure($sformatf("unexpected report transaction: page %h valid %b",
                               got.slot_page, got.slot_valid));
      end else begin
        want = frame_reports_q.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"report mismatch: exp page %h vld %b hit %0d miss %0d ",
                                  "ovf %b last %b, got page %h vld %b hit %0d miss %0d ",
                                  "ovf %b last %b"},
                                 want.slot_page, want.slot_valid, want.hit_count,
                                 want.miss_count, want.overflow, want.last_slot,
                                 got.slot_page, got.slot_valid, got.hit_count,
                                 got.miss_count, got.overflow, got.last_slot));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    res_bus.ready = steady_flow || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (ref_bus.valid && ref_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one reference string, last_ref on its final page
  task automatic send_pages(input logic [PageW-1:0] pages[$]);
    foreach (pages[i]) begin
      while (!steady_flow && $urandom_range(99) < IdlePercent) begin
        @(negedge clk_i);
        ref_bus.valid = 1'b0;
      end
      @(negedge clk_i);
      ref_bus.valid       = 1'b1;
      ref_bus.page_number = pages[i];
      ref_bus.last_ref    = (i == pages.size() - 1);
      do @(posedge clk_i); while (!ref_bus.ready);
      refs_sent++;
    end
    strings_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    ref_bus.valid = 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    config_writes++;
  endtask

  task automatic apb_read(input logic [CfgAddrW-1:0] addr, output logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_frame_count(input logic [FcW-1:0] fc, input bit noisy_upper);
    logic [CfgDataW-1:0] wdata, rdata;
    settle_idle();
    wdata = noisy_upper ? (($urandom() & ~CfgDataW'(4'hF)) | CfgDataW'(fc)) : CfgDataW'(fc);
    apb_write(FrameCountAddr, wdata);
    apb_read(FrameCountAddr, rdata);
    if (rdata[FcW-1:0] !== fc) begin
      note_failure($sformatf("frame_count readback: exp %0d got %0d", fc, rdata[FcW-1:0]));
    end
  endtask

  task automatic test_reset_default();
    logic [PageW-1:0] q[$];
    q = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hFFFF};
    send_pages(q);
  endtask

  task automatic test_frame_limits();
    logic [PageW-1:0] q[$];
    set_frame_count(4'd1, 1'b0);
    q = '{16'h0001, 16'h0002, 16'h0001, 16'h0001};
    send_pages(q);
    set_frame_count(4'd0, 1'b0);
    q = '{16'h8001};
    send_pages(q);
    set_frame_count(4'd8, 1'b0);
    settle_idle();
    apb_write(UnmappedAddr, CfgDataW'(1));
    q = '{16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060, 16'h0070, 16'h0080,
          16'h0090, 16'h0010};
    send_pages(q);
    set_frame_count(4'd15, 1'b0);
    q = '{16'h0003, 16'h0003};
    send_pages(q);
  endtask

  task automatic test_eviction_choice();
    logic [PageW-1:0] q[$];
    set_frame_count(4'd3, 1'b0);
    q = '{16'd7, 16'd0, 16'd1, 16'd2, 16'd0, 16'd3, 16'd0, 16'd4, 16'd2, 16'd3, 16'd0,
          16'd3, 16'd2};
    send_pages(q);
  endtask

  task automatic test_store_overflow();
    logic [PageW-1:0] q[$];
    set_frame_count(4'd2, 1'b0);
    for (int i = 0; i < MaxRefsDef + 2; i++) q.push_back(PageW'($urandom_range(2)) + 16'h0100);
    send_pages(q);
  endtask

  task automatic test_random_strings();
    logic [PageW-1:0] pool[$];
    logic [PageW-1:0] q[$];
    int               stop_at, phase, len, pick;
    stop_at = refs_sent + RandomRefs;
    phase   = 0;
    while (refs_sent < stop_at) begin
      set_frame_count(FcW'($urandom_range(15)), 1'b1);
      steady_flow = (phase == 2);
      repeat ($urandom_range(4, 1)) begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(12, 1);
        else if (pick < 92) len = $urandom_range(MaxRefsDef, 13);
        else len = $urandom_range(MaxRefsDef + 8, MaxRefsDef + 1);
        pool.delete();
        repeat ($urandom_range(10, 1)) pool.push_back(PageW'($urandom()));
        q.delete();
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 85) q.push_back(pool[$urandom_range(pool.size() - 1)]);
          else q.push_back(PageW'($urandom()));
        end
        send_pages(q);
      end
      steady_flow = 1'b0;
      phase++;
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    ref_bus.valid       = 1'b0;
    ref_bus.page_number = '0;
    ref_bus.last_ref    = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    steady_flow         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_default();
    test_frame_limits();
    test_eviction_choice();
    test_store_overflow();
    test_random_strings();
    settle_idle();

    failures += frame_reports_q.size();
    $display("ran %0d reference strings (%0d references) under %0d register writes",
             strings_sent, refs_sent, config_writes);
    $display("checked %0d frame reports, %0d failures", reports_seen, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
